// ===== rtl/bmlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED pattern controller package
// Shared types, register indexes, constants and segment tables.
// ----------------------------------------------------------------------------
package bmlp_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 12;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE_TICKS = 3'd0,
      CSR_SELECT_WINDOW  = 3'd1,
      CSR_FLASH_TICKS    = 3'd2,
      CSR_STROBE_PERIOD  = 3'd3,
      CSR_STROBE_ON      = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_WAIT_PRESS    = 3'd0,
      PH_SETTLE_PRESS  = 3'd1,
      PH_WAIT_RELEASE  = 3'd2,
      PH_SETTLE_RELEASE = 3'd3,
      PH_FLASH         = 3'd4,
      PH_SELECT        = 3'd5,
      PH_RUN           = 3'd6
   } phase_type;

   localparam logic [1:0] MODE_SLOW   = 2'd0;
   localparam logic [1:0] MODE_DOUBLE = 2'd1;
   localparam logic [1:0] MODE_FAST   = 2'd2;

   localparam logic [1:0] ACTION_NORMAL = 2'd0;
   localparam logic [1:0] ACTION_INVERT = 2'd1;
   localparam logic [1:0] ACTION_STROBE = 2'd2;

   localparam logic [1:0] SELECTOR_LAST = 2'd3;
   localparam logic [1:0] PRESS_MAX     = 2'd3;

   localparam logic [12:0] SETTLE_PRESS_TICKS   = 13'd20;
   localparam logic [12:0] SETTLE_RELEASE_TICKS = 13'd25;
   localparam logic [6:0]  SINCE_MAX            = 7'd127;

   localparam logic [6:0]  DEBOUNCE_RESET = 7'd25;
   localparam logic [11:0] SELECT_RESET   = 12'd2000;
   localparam logic [11:0] FLASH_RESET    = 12'd200;
   localparam logic [7:0]  PERIOD_RESET   = 8'd120;
   localparam logic [7:0]  STROBE_ON_RESET = 8'd18;

   typedef struct packed {
      logic [6:0]  debounce_ticks;
      logic [11:0] select_window;
      logic [11:0] flash_ticks;
      logic [7:0]  strobe_period;
      logic [7:0]  strobe_on;
   } cfg_type;

   typedef struct packed {
      logic       led_on;
      logic [2:0] phase_code;
      logic [1:0] mode_code;
      logic [1:0] action_code;
   } result_type;

   // Highest segment index of a pattern row; segment counts are powers of two.
   function automatic logic [1:0] seg_last(input logic [1:0] row);
      logic [1:0] last;
      last = (row == MODE_DOUBLE) ? 2'd3 : 2'd1;
      return last;
   endfunction

   function automatic logic [9:0] seg_len(input logic [1:0] row, input logic [1:0] idx);
      logic [9:0] len;
      case (row)
         MODE_SLOW: begin
            len = 10'd400;
         end
         MODE_DOUBLE: begin
            len = (idx == 2'd3) ? 10'd500 : 10'd120;
         end
         default: begin
            len = 10'd60;
         end
      endcase
      return len;
   endfunction

   function automatic logic seg_lit(input logic [1:0] idx);
      logic lit;
      lit = ~idx[0];
      return lit;
   endfunction

endpackage

// ===== rtl/bmlp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED pattern controller channel interfaces
// Valid/ready channels for request, response and register write beats.
// ----------------------------------------------------------------------------
interface bmlp_req_if;
   logic valid;
   logic ready;
   logic button_level;

   modport source (output valid, output button_level, input ready);
   modport sink (input valid, input button_level, output ready);
endinterface

interface bmlp_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_on;
   logic [2:0] phase_code;
   logic [1:0] mode_code;
   logic [1:0] action_code;

   modport source (output valid, output led_on, output phase_code, output mode_code,
                   output action_code, input ready);
   modport sink (input valid, input led_on, input phase_code, input mode_code,
                 input action_code, output ready);
endinterface

interface bmlp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bmlp_pkg::CsrIndexWidth-1:0]  index;
   logic [bmlp_pkg::CsrDataWidth-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bmlp_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED pattern controller registers
// Holds the timing registers, written one beat at a time.
// ----------------------------------------------------------------------------
module bmlp_csr (
   input  logic              clock,
   input  logic              reset,
   bmlp_csr_if.sink          csr_chan,
   output bmlp_pkg::cfg_type cfg
);

   bmlp_pkg::cfg_type cfg_ff;
   bmlp_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            bmlp_pkg::CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_chan.data[6:0];
            bmlp_pkg::CSR_SELECT_WINDOW:  cfg_in.select_window  = csr_chan.data[11:0];
            bmlp_pkg::CSR_FLASH_TICKS:    cfg_in.flash_ticks    = csr_chan.data[11:0];
            bmlp_pkg::CSR_STROBE_PERIOD:  cfg_in.strobe_period  = csr_chan.data[7:0];
            bmlp_pkg::CSR_STROBE_ON:      cfg_in.strobe_on      = csr_chan.data[7:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= bmlp_pkg::DEBOUNCE_RESET;
         cfg_ff.select_window  <= bmlp_pkg::SELECT_RESET;
         cfg_ff.flash_ticks    <= bmlp_pkg::FLASH_RESET;
         cfg_ff.strobe_period  <= bmlp_pkg::PERIOD_RESET;
         cfg_ff.strobe_on      <= bmlp_pkg::STROBE_ON_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/bmlp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED pattern controller sequencer
// Phase machine, debouncer, press counter and pattern player, one tick a beat.
// ----------------------------------------------------------------------------
module bmlp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 button_level,
   input  bmlp_pkg::cfg_type    cfg,
   output bmlp_pkg::result_type result
);

   bmlp_pkg::phase_type phase_ff, phase_in;
   logic [11:0] wait_ff, wait_in;
   logic        last_raw_ff, last_raw_in;
   logic        stable_ff, stable_in;
   logic [6:0]  since_ff, since_in;
   logic [1:0]  press_ff, press_in;
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  selector_ff, selector_in;
   logic [1:0]  action_ff, action_in;
   logic [1:0]  seg_index_ff, seg_index_in;
   logic [8:0]  elapsed_ff, elapsed_in;
   logic [7:0]  strobe_ff, strobe_in;

   logic        dbn_last;
   logic [6:0]  dbn_since;
   logic        dbn_follow;
   logic        dbn_stable;
   logic        dbn_press;
   logic [12:0] wait_inc;
   logic [1:0]  press_next;
   logic [1:0]  row;
   logic [1:0]  idx;
   logic        lit;
   logic [1:0]  sel_next;
   logic [1:0]  act_next;
   logic [9:0]  elapsed_inc;
   logic [8:0]  strobe_inc;
   logic        seg_done;
   logic        run_led;
   logic        led;

   always_comb begin
      dbn_last  = last_raw_ff;
      dbn_since = since_ff;
      if (button_level != last_raw_ff) begin
         dbn_last  = button_level;
         dbn_since = 7'd0;
      end else if (since_ff != bmlp_pkg::SINCE_MAX) begin
         dbn_since = since_ff + 7'd1;
      end
      dbn_follow = (dbn_since >= cfg.debounce_ticks) && (button_level != stable_ff);
      dbn_stable = dbn_follow ? button_level : stable_ff;
      dbn_press  = dbn_follow && !button_level;

      wait_inc   = {1'b0, wait_ff} + 13'd1;
      press_next = (dbn_press && press_ff != bmlp_pkg::PRESS_MAX) ? press_ff + 2'd1 : press_ff;

      row = (mode_ff == bmlp_pkg::MODE_SLOW || mode_ff == bmlp_pkg::MODE_DOUBLE) ?
            mode_ff : bmlp_pkg::MODE_FAST;
      idx = seg_index_ff & bmlp_pkg::seg_last(row);
      lit = bmlp_pkg::seg_lit(idx);

      sel_next = selector_ff;
      act_next = action_ff;
      if (dbn_press) begin
         sel_next = (selector_ff == bmlp_pkg::SELECTOR_LAST) ? 2'd1 : selector_ff + 2'd1;
         act_next = (sel_next == bmlp_pkg::SELECTOR_LAST) ? bmlp_pkg::ACTION_NORMAL : sel_next;
      end

      case (act_next)
         bmlp_pkg::ACTION_INVERT: run_led = ~lit;
         bmlp_pkg::ACTION_STROBE: run_led = lit && (strobe_ff < cfg.strobe_on);
         default:                 run_led = lit;
      endcase

      elapsed_inc = {1'b0, elapsed_ff} + 10'd1;
      strobe_inc  = {1'b0, strobe_ff} + 9'd1;
      seg_done    = elapsed_inc >= bmlp_pkg::seg_len(row, idx);
   end

   always_comb begin
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      last_raw_in  = last_raw_ff;
      stable_in    = stable_ff;
      since_in     = since_ff;
      press_in     = press_ff;
      mode_in      = mode_ff;
      selector_in  = selector_ff;
      action_in    = action_ff;
      seg_index_in = seg_index_ff;
      elapsed_in   = elapsed_ff;
      strobe_in    = strobe_ff;
      case (phase_ff)
         bmlp_pkg::PH_SETTLE_PRESS: begin
            wait_in = wait_inc[11:0];
            if (wait_inc >= bmlp_pkg::SETTLE_PRESS_TICKS) begin
               phase_in = bmlp_pkg::PH_WAIT_RELEASE;
               wait_in  = 12'd0;
            end
         end
         bmlp_pkg::PH_WAIT_RELEASE: begin
            if (button_level) begin
               phase_in = bmlp_pkg::PH_SETTLE_RELEASE;
               wait_in  = 12'd0;
            end
         end
         bmlp_pkg::PH_SETTLE_RELEASE: begin
            wait_in = wait_inc[11:0];
            if (wait_inc >= bmlp_pkg::SETTLE_RELEASE_TICKS) begin
               phase_in = bmlp_pkg::PH_FLASH;
               wait_in  = 12'd0;
            end
         end
         bmlp_pkg::PH_FLASH: begin
            wait_in = wait_inc[11:0];
            if (wait_inc >= {1'b0, cfg.flash_ticks}) begin
               phase_in    = bmlp_pkg::PH_SELECT;
               wait_in     = 12'd0;
               press_in    = 2'd0;
               last_raw_in = 1'b1;
               stable_in   = 1'b1;
               since_in    = bmlp_pkg::SINCE_MAX;
            end
         end
         bmlp_pkg::PH_SELECT: begin
            last_raw_in = dbn_last;
            stable_in   = dbn_stable;
            since_in    = dbn_since;
            press_in    = press_next;
            wait_in     = wait_inc[11:0];
            if (wait_inc >= {1'b0, cfg.select_window}) begin
               mode_in      = (press_next <= 2'd1) ? bmlp_pkg::MODE_SLOW :
                              ((press_next == 2'd2) ? bmlp_pkg::MODE_DOUBLE : bmlp_pkg::MODE_FAST);
               phase_in     = bmlp_pkg::PH_RUN;
               wait_in      = 12'd0;
               selector_in  = 2'd0;
               action_in    = bmlp_pkg::ACTION_NORMAL;
               seg_index_in = 2'd0;
               elapsed_in   = 9'd0;
               strobe_in    = 8'd0;
               last_raw_in  = 1'b1;
               stable_in    = 1'b1;
               since_in     = bmlp_pkg::SINCE_MAX;
            end
         end
         bmlp_pkg::PH_RUN: begin
            last_raw_in = dbn_last;
            stable_in   = dbn_stable;
            since_in    = dbn_since;
            selector_in = sel_next;
            action_in   = act_next;
            elapsed_in  = elapsed_inc[8:0];
            strobe_in   = (strobe_inc >= {1'b0, cfg.strobe_period} || strobe_inc[8]) ?
                          8'd0 : strobe_inc[7:0];
            seg_index_in = idx;
            if (seg_done) begin
               seg_index_in = (idx + 2'd1) & bmlp_pkg::seg_last(row);
               elapsed_in   = 9'd0;
               strobe_in    = 8'd0;
            end
         end
         default: begin
            phase_in = bmlp_pkg::PH_WAIT_PRESS;
            if (!button_level) begin
               phase_in = bmlp_pkg::PH_SETTLE_PRESS;
               wait_in  = 12'd0;
            end
         end
      endcase
   end

   always_comb begin
      case (phase_ff)
         bmlp_pkg::PH_SETTLE_RELEASE: led = wait_inc >= bmlp_pkg::SETTLE_RELEASE_TICKS;
         bmlp_pkg::PH_FLASH:          led = !(wait_inc >= {1'b0, cfg.flash_ticks});
         bmlp_pkg::PH_RUN:            led = run_led;
         default:                     led = 1'b0;
      endcase
      result.led_on      = led;
      result.phase_code  = phase_in;
      result.mode_code   = mode_in;
      result.action_code = action_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bmlp_pkg::PH_WAIT_PRESS;
         wait_ff      <= 12'd0;
         last_raw_ff  <= 1'b1;
         stable_ff    <= 1'b1;
         since_ff     <= bmlp_pkg::SINCE_MAX;
         press_ff     <= 2'd0;
         mode_ff      <= bmlp_pkg::MODE_SLOW;
         selector_ff  <= 2'd0;
         action_ff    <= bmlp_pkg::ACTION_NORMAL;
         seg_index_ff <= 2'd0;
         elapsed_ff   <= 9'd0;
         strobe_ff    <= 8'd0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         last_raw_ff  <= last_raw_in;
         stable_ff    <= stable_in;
         since_ff     <= since_in;
         press_ff     <= press_in;
         mode_ff      <= mode_in;
         selector_ff  <= selector_in;
         action_ff    <= action_in;
         seg_index_ff <= seg_index_in;
         elapsed_ff   <= elapsed_in;
         strobe_ff    <= strobe_in;
      end
   end

endmodule

// ===== rtl/button_mode_led_pattern_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED pattern controller
// Each request beat is one millisecond tick carrying the raw button level; each
// produces one response beat with the LED level and the current phase, mode and
// action. The block takes one beat per clock cycle while the response side is
// free. A beat is held in an input register, advances all state and lands in
// the response register; both registers keep moving while the response side
// accepts every cycle. The user must write timing registers through the register
// port only while no beats are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module button_mode_led_pattern_controller (
   input  logic        clock,
   input  logic        reset,
   bmlp_req_if.sink    req_chan,
   bmlp_rsp_if.source  rsp_chan,
   bmlp_csr_if.sink    csr_chan
);

   bmlp_pkg::cfg_type    cfg;
   bmlp_pkg::result_type result;
   bmlp_pkg::result_type rsp_data_ff;

   logic in_valid_ff;
   logic in_level_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic fire;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   bmlp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   bmlp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .button_level (in_level_ff),
      .cfg          (cfg),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_level_ff <= req_chan.button_level;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.led_on      = rsp_data_ff.led_on;
   assign rsp_chan.phase_code  = rsp_data_ff.phase_code;
   assign rsp_chan.mode_code   = rsp_data_ff.mode_code;
   assign rsp_chan.action_code = rsp_data_ff.action_code;

endmodule

// ===== dv/button_mode_led_pattern_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode LED pattern controller testbench
// Drives one boot sequence (press, release, flash, press counting) into the
// controller and then long stretches of run traffic under many timing
// register settings. Every response beat is checked field by field against
// a cycle-free model of the controller kept in this file. Both channels
// idle at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module button_mode_led_pattern_controller_test;
   import bmlp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmlp_req_if button_chan ();
   bmlp_rsp_if led_chan ();
   bmlp_csr_if reg_chan ();

   button_mode_led_pattern_controller i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (button_chan),
      .rsp_chan (led_chan),
      .csr_chan (reg_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Timing registers as the controller should hold them.
   logic [6:0]  cfg_debounce = DEBOUNCE_RESET;
   logic [11:0] cfg_select   = SELECT_RESET;
   logic [11:0] cfg_flash    = FLASH_RESET;
   logic [7:0]  cfg_period   = PERIOD_RESET;
   logic [7:0]  cfg_strobe   = STROBE_ON_RESET;

   // Controller state as it should evolve.
   phase_type  ph          = PH_WAIT_PRESS;
   logic [11:0] tick_wait  = '0;
   logic       db_last     = 1'b1;
   logic       db_stable   = 1'b1;
   logic [6:0] db_since    = SINCE_MAX;
   logic [1:0] press_tally = '0;
   logic [1:0] mode_sel    = MODE_SLOW;
   logic [1:0] selector    = '0;
   logic [1:0] act_sel     = ACTION_NORMAL;
   logic [1:0] seg_idx     = '0;
   logic [8:0] seg_elapsed = '0;
   logic [7:0] strobe_ph   = '0;

   logic       button_ticks[$];
   result_type pending_led_states[$];
   bit         tick_taken = 1'b0;
   int         ticks_queued = 0;
   int         ticks_taken = 0;
   int         led_beats = 0;
   int         reg_writes = 0;
   int         mismatches = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;

   function automatic void rearm_debounce();
      db_last   = 1'b1;
      db_stable = 1'b1;
      db_since  = SINCE_MAX;
   endfunction

   // Returns one when the debounced level falls to pressed on this tick.
   function automatic logic debounce_falls(input logic raw);
      logic fell;
      fell = 1'b0;
      if (raw != db_last) begin
         db_last  = raw;
         db_since = '0;
      end else if (db_since < SINCE_MAX) begin
         db_since = db_since + 7'd1;
      end
      if (db_since >= cfg_debounce && raw != db_stable) begin
         db_stable = raw;
         fell      = ~raw;
      end
      return fell;
   endfunction

   function automatic result_type step_controller(input logic raw);
      result_type beat;
      logic [1:0] row;
      logic [1:0] last_idx;
      logic [1:0] idx;
      logic       lit;
      logic [9:0] seg_ticks;
      logic [8:0] strobe_next;
      beat.led_on = 1'b0;
      case (ph)
         PH_SETTLE_PRESS: begin
            tick_wait = tick_wait + 12'd1;
            if ({1'b0, tick_wait} >= SETTLE_PRESS_TICKS) begin
               ph        = PH_WAIT_RELEASE;
               tick_wait = '0;
            end
         end
         PH_WAIT_RELEASE: begin
            if (raw) begin
               ph        = PH_SETTLE_RELEASE;
               tick_wait = '0;
            end
         end
         PH_SETTLE_RELEASE: begin
            tick_wait = tick_wait + 12'd1;
            if ({1'b0, tick_wait} >= SETTLE_RELEASE_TICKS) begin
               ph          = PH_FLASH;
               tick_wait   = '0;
               beat.led_on = 1'b1;
            end
         end
         PH_FLASH: begin
            tick_wait = tick_wait + 12'd1;
            if (tick_wait >= cfg_flash) begin
               ph          = PH_SELECT;
               tick_wait   = '0;
               press_tally = '0;
               rearm_debounce();
            end else begin
               beat.led_on = 1'b1;
            end
         end
         PH_SELECT: begin
            if (debounce_falls(raw) && press_tally < PRESS_MAX) begin
               press_tally = press_tally + 2'd1;
            end
            tick_wait = tick_wait + 12'd1;
            if (tick_wait >= cfg_select) begin
               mode_sel = (press_tally <= 2'd1) ? MODE_SLOW :
                          (press_tally == 2'd2) ? MODE_DOUBLE : MODE_FAST;
               ph          = PH_RUN;
               tick_wait   = '0;
               selector    = '0;
               act_sel     = ACTION_NORMAL;
               seg_idx     = '0;
               seg_elapsed = '0;
               strobe_ph   = '0;
               rearm_debounce();
            end
         end
         PH_RUN: begin
            row      = (mode_sel < MODE_FAST) ? mode_sel : MODE_FAST;
            last_idx = (row == MODE_DOUBLE) ? 2'd3 : 2'd1;
            idx      = seg_idx & last_idx;
            if (debounce_falls(raw)) begin
               selector = (selector == SELECTOR_LAST) ? 2'd1 : selector + 2'd1;
               act_sel  = (selector == SELECTOR_LAST) ? ACTION_NORMAL : selector;
            end
            lit = (idx == 2'd0) || (row == MODE_DOUBLE && idx == 2'd2);
            case (act_sel)
               ACTION_INVERT: begin
                  beat.led_on = ~lit;
               end
               ACTION_STROBE: begin
                  beat.led_on = lit && (strobe_ph < cfg_strobe);
               end
               default: begin
                  beat.led_on = lit;
               end
            endcase
            if (row == MODE_SLOW) begin
               seg_ticks = 10'd400;
            end else if (row == MODE_DOUBLE) begin
               seg_ticks = (idx == 2'd3) ? 10'd500 : 10'd120;
            end else begin
               seg_ticks = 10'd60;
            end
            seg_elapsed = seg_elapsed + 9'd1;
            strobe_next = {1'b0, strobe_ph} + 9'd1;
            strobe_ph   = (strobe_next >= {1'b0, cfg_period} || strobe_next[8]) ?
                          8'd0 : strobe_next[7:0];
            if ({1'b0, seg_elapsed} >= seg_ticks) begin
               seg_idx     = (idx + 2'd1) & last_idx;
               seg_elapsed = '0;
               strobe_ph   = '0;
            end else begin
               seg_idx = idx;
            end
         end
         default: begin
            ph = PH_WAIT_PRESS;
            if (!raw) begin
               ph        = PH_SETTLE_PRESS;
               tick_wait = '0;
            end
         end
      endcase
      beat.phase_code  = ph;
      beat.mode_code   = mode_sel;
      beat.action_code = act_sel;
      return beat;
   endfunction

   function automatic void report_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Button driver: holds a beat until it is taken, then may idle before the next one.
   always @(negedge clock) begin
      if (reset) begin
         button_chan.valid <= 1'b0;
      end else if (!button_chan.valid || tick_taken) begin
         tick_taken = 1'b0;
         if (button_ticks.size() != 0 &&
             ((ticks_taken >= 700 && ticks_taken < 1000) || $urandom_range(0, 99) >= 8)) begin
            button_chan.valid        <= 1'b1;
            button_chan.button_level <= button_ticks[0];
         end else begin
            button_chan.valid <= 1'b0;
         end
      end
   end

   // LED side ready, with one long hold-off so the controller backs up.
   always @(negedge clock) begin
      if (reset) begin
         led_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         led_chan.ready <= 1'b0;
      end else if (!hold_done && led_beats >= 400 && button_ticks.size() >= 16) begin
         hold_done = 1'b1;
         hold_left = 150;
         led_chan.ready <= 1'b0;
      end else if (led_beats >= 700 && led_beats < 1000) begin
         led_chan.ready <= 1'b1;
      end else begin
         led_chan.ready <= ($urandom_range(0, 99) >= 8);
      end
   end

   always @(posedge clock) begin : watch
      result_type want;
      if (!reset) begin
         if (button_chan.valid && button_chan.ready) begin
            pending_led_states.push_back(step_controller(button_chan.button_level));
            void'(button_ticks.pop_front());
            tick_taken = 1'b1;
            ticks_taken++;
         end
         if (led_chan.valid && led_chan.ready) begin
            led_beats++;
            if (pending_led_states.size() == 0) begin
               mismatches++;
               $display("%0t ns: expected no beat, got led %0d phase %0d mode %0d action %0d",
                        $time, led_chan.led_on, led_chan.phase_code, led_chan.mode_code,
                        led_chan.action_code);
            end else begin
               want = pending_led_states.pop_front();
               report_field("led_on", int'(want.led_on), int'(led_chan.led_on));
               report_field("phase_code", int'(want.phase_code), int'(led_chan.phase_code));
               report_field("mode_code", int'(want.mode_code), int'(led_chan.mode_code));
               report_field("action_code", int'(want.action_code),
                            int'(led_chan.action_code));
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input int value);
      @(negedge clock);
      reg_chan.valid <= 1'b1;
      reg_chan.index <= idx;
      reg_chan.data  <= value[11:0];
      @(posedge clock);
      while (!reg_chan.ready) @(posedge clock);
      case (idx)
         CSR_DEBOUNCE_TICKS: cfg_debounce = value[6:0];
         CSR_SELECT_WINDOW:  cfg_select   = value[11:0];
         CSR_FLASH_TICKS:    cfg_flash    = value[11:0];
         CSR_STROBE_PERIOD:  cfg_period   = value[7:0];
         CSR_STROBE_ON:      cfg_strobe   = value[7:0];
         default: begin
         end
      endcase
      reg_writes++;
      @(negedge clock);
      reg_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (button_ticks.size() != 0 || button_chan.valid || pending_led_states.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_ticks(input logic level, input int count);
      repeat (count) button_ticks.push_back(level);
      ticks_queued += count;
   endtask

   task automatic add_noise(input int count);
      repeat (count) button_ticks.push_back(1'($urandom_range(0, 1)));
      ticks_queued += count;
   endtask

   // Mostly clean presses that the debouncer accepts, with glitches and noise.
   task automatic add_run_traffic(input int count);
      int start;
      int hold;
      hold  = int'(cfg_debounce);
      start = ticks_queued;
      while (ticks_queued - start < count) begin
         case ($urandom_range(0, 9))
            0: begin
               add_noise($urandom_range(1, 8));
            end
            1: begin
               add_ticks(1'b0, (hold == 0) ? 1 : $urandom_range(1, hold));
               add_ticks(1'b1, hold + 1);
            end
            default: begin
               add_ticks(1'b0, hold + 1 + $urandom_range(0, 30));
               add_ticks(1'b1, hold + 1 + $urandom_range(0, 30));
            end
         endcase
      end
   endtask

   initial begin
      int hold;
      int presses_wanted;
      int window;
      int used;
      int run_len;
      int settings;
      int k;
      int period_val;

      button_chan.valid        = 1'b0;
      button_chan.button_level = 1'b1;
      led_chan.ready           = 1'b0;
      reg_chan.valid           = 1'b0;
      reg_chan.index           = CSR_DEBOUNCE_TICKS;
      reg_chan.data            = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Boot settings: now and then the reset values stay for the flash phase.
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_DEBOUNCE_TICKS, $urandom_range(0, 6));
         case ($urandom_range(0, 3))
            0: write_reg(CSR_FLASH_TICKS, 0);
            1: write_reg(CSR_FLASH_TICKS, 1);
            default: write_reg(CSR_FLASH_TICKS, $urandom_range(2, 300));
         endcase
      end
      hold           = int'(cfg_debounce);
      presses_wanted = $urandom_range(0, 4);
      if (presses_wanted == 0) begin
         case ($urandom_range(0, 2))
            0: window = 0;
            1: window = 1;
            default: window = $urandom_range(2, 200);
         endcase
      end else begin
         window = presses_wanted * (2 * hold + 6) + $urandom_range(0, 60);
      end
      write_reg(CSR_SELECT_WINDOW, window);
      settings = 1;

      // The boot sequence: press, settle, release, settle, flash, press counting.
      add_ticks(1'b1, $urandom_range(1, 5));
      add_ticks(1'b0, 1);
      add_noise(int'(SETTLE_PRESS_TICKS));
      add_ticks(1'b0, $urandom_range(0, 4));
      add_ticks(1'b1, 1);
      add_noise(int'(SETTLE_RELEASE_TICKS));
      add_noise((cfg_flash == 0) ? 1 : int'(cfg_flash));
      used = 0;
      repeat (presses_wanted) begin
         run_len = hold + 1 + $urandom_range(0, 2);
         add_ticks(1'b0, run_len);
         used += run_len;
         run_len = hold + 1 + $urandom_range(0, 2);
         add_ticks(1'b1, run_len);
         used += run_len;
      end
      add_ticks(1'b1, ((window == 0) ? 1 : window) - used);
      add_run_traffic(150);

      k = 0;
      while (k < 4 || ticks_queued < 1600) begin
         wait_drained();
         case (k)
            0: begin
               write_reg(CSR_DEBOUNCE_TICKS, 0);
               write_reg(CSR_STROBE_PERIOD, 0);
               write_reg(CSR_STROBE_ON, 0);
            end
            1: begin
               write_reg(CSR_DEBOUNCE_TICKS, 4095);
               write_reg(CSR_STROBE_PERIOD, 255);
               write_reg(CSR_STROBE_ON, 255);
               write_reg(CSR_SELECT_WINDOW, 4095);
               write_reg(CSR_FLASH_TICKS, 4095);
            end
            2: begin
               write_reg(CSR_DEBOUNCE_TICKS, 1);
               write_reg(CSR_STROBE_PERIOD, 1);
               write_reg(CSR_STROBE_ON, 0);
               write_reg(CSR_SELECT_WINDOW, 0);
               write_reg(CSR_FLASH_TICKS, 0);
            end
            3: begin
               write_reg(CSR_DEBOUNCE_TICKS, 100);
               write_reg(CSR_STROBE_PERIOD, 255);
               write_reg(CSR_STROBE_ON, 1);
            end
            default: begin
               write_reg(CSR_DEBOUNCE_TICKS, ($urandom_range(0, 5) == 0) ?
                         $urandom_range(0, 4095) : $urandom_range(0, 12));
               case ($urandom_range(0, 3))
                  0: period_val = 0;
                  1: period_val = $urandom_range(1, 8);
                  default: period_val = $urandom_range(1, 255);
               endcase
               write_reg(CSR_STROBE_PERIOD, period_val);
               write_reg(CSR_STROBE_ON, ($urandom_range(0, 3) == 0) ?
                         $urandom_range(0, 4095) : $urandom_range(0, period_val));
               if ($urandom_range(0, 3) == 0) begin
                  write_reg(CSR_SELECT_WINDOW, $urandom_range(0, 4095));
                  write_reg(CSR_FLASH_TICKS, $urandom_range(0, 4095));
               end
            end
         endcase
         settings++;
         k++;
         add_run_traffic(100 + 2 * int'(cfg_debounce));
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Checked %0d button ticks across %0d register settings (%0d writes).",
               ticks_taken, settings, reg_writes);
      $display("Pattern mode %0d was chosen from %0d planned presses.",
               mode_sel, presses_wanted);
      if (mismatches == 0) begin
         $display("button_mode_led_pattern_controller: match");
      end else begin
         $display("button_mode_led_pattern_controller: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d ticks taken.", ticks_taken);
      $display("button_mode_led_pattern_controller: mismatch");
      $finish;
   end

endmodule
